// ----- sv/cass_pkg.sv -----
// shared types, constants and slot helpers for the calendar slot alarm scheduler
// no dependencies; used by cass_mod_unit and the top level
`default_nettype none
package cass_pkg;

   localparam int SLOTS          = 4;
   localparam int LOOKAHEAD_DAYS = 15;
   localparam int SLOT_BITS      = 11;
   localparam int TABLE_W        = 44;
   localparam int SIW            = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W          = $clog2(SLOTS + 1);
   localparam int DIV_W          = 18;
   localparam int DCNT_W         = $clog2(DIV_W + 1);
   localparam int OFF_W          = 10;

   localparam logic [15:0] REF_UNSET  = 16'hFFFF;
   localparam logic [31:0] DUP_WINDOW = 32'd7200;

   localparam logic [1:0] PAT_DAILY    = 2'd0;
   localparam logic [1:0] PAT_MASK     = 2'd1;
   localparam logic [1:0] PAT_INTERVAL = 2'd2;

   localparam logic [2:0] REG_DAY_PATTERN = 3'd0;
   localparam logic [2:0] REG_WEEKDAY     = 3'd1;
   localparam logic [2:0] REG_INTERVAL    = 3'd2;
   localparam logic [2:0] REG_SLOT_COUNT  = 3'd3;
   localparam logic [2:0] REG_SLOT_TABLE  = 3'd4;
   localparam logic [2:0] REG_INIT_REF    = 3'd5;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [7:0]       divisor;
   } div_req_type;

   typedef struct packed {
      logic       done;
      logic [7:0] rem;
   } div_rsp_type;

   function automatic logic [5:0] slot_minute(input logic [TABLE_W-1:0] tbl,
                                              input logic [SIW-1:0] idx);
      logic [SLOT_BITS-1:0] w;
      w = tbl[SLOT_BITS*idx +: SLOT_BITS];
      return w[5:0];
   endfunction

   function automatic logic [4:0] slot_hour(input logic [TABLE_W-1:0] tbl,
                                            input logic [SIW-1:0] idx);
      logic [SLOT_BITS-1:0] w;
      w = tbl[SLOT_BITS*idx +: SLOT_BITS];
      return w[10:6];
   endfunction

   // (day + 4) mod 7 by folding octal digits, since 8 mod 7 is 1
   function automatic logic [2:0] weekday_of(input logic [15:0] day);
      logic [16:0] v;
      logic [5:0]  s1;
      logic [3:0]  s2;
      v  = {1'b0, day} + 17'd4;
      s1 = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9]) + 6'(v[14:12])
           + 6'(v[16:15]);
      s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
      return (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
   endfunction

endpackage
`default_nettype wire

// ----- sv/cass_mod_unit.sv -----
// shared restoring remainder unit, one dividend bit per cycle
// depends on cass_pkg
`default_nettype none
module cass_mod_unit (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cass_pkg::div_req_type req,
   output cass_pkg::div_rsp_type      rsp
);
   import cass_pkg::*;

   logic [DIV_W-1:0]  dvd_ff, dvd_in;
   logic [7:0]        div_ff, div_in;
   logic [7:0]        rem_ff, rem_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [8:0]        trial;

   always_comb begin
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, dvd_ff[DIV_W-1]};
      if (req.start) begin
         dvd_in  = req.dividend;
         div_in  = req.divisor;
         rem_in  = '0;
         cnt_in  = DCNT_W'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = 8'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[7:0];
         end
         dvd_in = {dvd_ff[DIV_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign rsp.done = done_ff;
   assign rsp.rem  = rem_ff;

   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> rem_ff < div_ff)
      else $error("remainder not below divisor");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("done without a running division");
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff && cnt_ff > DCNT_W'(1) |=> busy_ff)
      else $error("division ended early");

endmodule
`default_nettype wire

// ----- sv/calendar_slot_alarm_scheduler_core.sv -----
// top level of the calendar slot alarm scheduler: sequencer, state and channels
// depends on cass_pkg and cass_mod_unit
//
// channel | dir | handshake            | payload
// req     | in  | req_tvalid/tready    | tdata day,hour,minute,epoch,busy; tuser kind
// rsp     | out | rsp_tvalid/tready    | tdata next slot, flags
// csr     | in  | csr_valid/csr_ready  | csr_index, csr_wdata
//
// a transaction is accepted in idle, prepared, then searched day by day;
// interval mode adds a remainder on the shared 18-step unit for the offset,
// for each of two candidate days and for the fire check.
// a tick with an unchanged minute is dropped in its accept cycle.
// synchronous reset; a finished result waits in the output register while
// the next transaction is accepted; csr writes are taken at any time.
`default_nettype none
module calendar_slot_alarm_scheduler_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // day_number[15:0], hour[20:16], minute[26:21], epoch_seconds[58:27], busy_req[59]
   input  wire logic [63:0] req_tdata,
   // kind[0]
   input  wire logic        req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // upcoming_hour[4:0], next_minute[10:5], next_day[26:11], next_found[27],
   // start_fire[28], duplicate_blocked[29], reference_latched[30]
   output logic [31:0]      rsp_tdata,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [43:0] csr_wdata
);
   import cass_pkg::*;

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_PREP      = 4'd1;
   localparam logic [3:0] ST_OFF_WAIT  = 4'd3;
   localparam logic [3:0] ST_DAY       = 4'd4;
   localparam logic [3:0] ST_DAY_WAIT  = 4'd5;
   localparam logic [3:0] ST_SLOT      = 4'd6;
   localparam logic [3:0] ST_NEXTDAY   = 4'd7;
   localparam logic [3:0] ST_FIRE_CHK  = 4'd8;
   localparam logic [3:0] ST_FIRE_WAIT = 4'd9;
   localparam logic [3:0] ST_FIRE_SLOT = 4'd10;
   localparam logic [3:0] ST_OUT       = 4'd11;

   logic [3:0]         state_ff, state_in;
   logic [1:0]         pat_ff, pat_in;
   logic [6:0]         mask_ff, mask_in;
   logic [7:0]         iv_ff, iv_in;
   logic [2:0]         scount_ff, scount_in;
   logic [TABLE_W-1:0] table_ff, table_in;
   logic [15:0]        ref_ff, ref_in;
   logic [6:0]         last_min_ff, last_min_in;
   logic [31:0]        fire_t_ff [SLOTS];
   logic [31:0]        fire_t_in [SLOTS];
   logic               kind_ff, kind_in;
   logic [15:0]        today_ff, today_in;
   logic [4:0]         hr_ff, hr_in;
   logic [5:0]         mn_ff, mn_in;
   logic [31:0]        now_ff, now_in;
   logic               busy_ff, busy_in;
   logic [15:0]        old_ref_ff, old_ref_in;
   logic [OFF_W-1:0]   off_ff, off_in;
   logic [OFF_W-1:0]   limit_ff, limit_in;
   logic [2:0]         wd_ff, wd_in;
   logic [2:0]         wd_today_ff, wd_today_in;
   logic [SIW-1:0]     slot_ff, slot_in;
   logic [4:0]         nhr_ff, nhr_in;
   logic [5:0]         nmn_ff, nmn_in;
   logic [15:0]        nday_ff, nday_in;
   logic               found_ff, found_in;
   logic               fire_ff, fire_in;
   logic               dup_ff, dup_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_data_ff, rsp_data_in;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic [CNT_W-1:0] n_act;
   logic             jump;
   logic [DIV_W-1:0] day_w;
   logic [15:0]      day_sat;
   logic [15:0]      ref_eff;
   logic [DIV_W-1:0] day_diff;
   logic [15:0]      today_diff;
   logic [15:0]      tref_eff;
   logic [15:0]      fire_diff;
   logic [4:0]       sh;
   logic [5:0]       sm;
   logic             last_slot;
   logic             req_acc;
   logic             csr_acc;
   logic [31:0]      t_cur;

   cass_mod_unit u_mod (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_acc    = csr_valid && csr_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      n_act = (scount_ff > 3'(SLOTS)) ? CNT_W'(SLOTS) : CNT_W'(scount_ff);
      jump  = (pat_ff == PAT_INTERVAL) && (iv_ff != 8'd0);
      day_w = DIV_W'(today_ff) + DIV_W'(off_ff);
      day_sat = (day_w[DIV_W-1:16] != '0) ? 16'hFFFF : day_w[15:0];
      ref_eff = (ref_ff == REF_UNSET) ? day_w[15:0] : ref_ff;
      day_diff = (day_w >= DIV_W'(ref_eff)) ? day_w - DIV_W'(ref_eff)
                                            : DIV_W'(ref_eff) - day_w;
      today_diff = (today_ff >= ref_ff) ? today_ff - ref_ff : ref_ff - today_ff;
      tref_eff   = (ref_ff == REF_UNSET) ? today_ff : ref_ff;
      fire_diff  = (today_ff >= tref_eff) ? today_ff - tref_eff : tref_eff - today_ff;
      sh = slot_hour(table_ff, slot_ff);
      sm = slot_minute(table_ff, slot_ff);
      last_slot = (CNT_W'(slot_ff) + 1'b1) >= n_act;
      t_cur = fire_t_ff[slot_ff];
   end

   always_comb begin
      state_in     = state_ff;
      pat_in       = pat_ff;
      mask_in      = mask_ff;
      iv_in        = iv_ff;
      scount_in    = scount_ff;
      table_in     = table_ff;
      ref_in       = ref_ff;
      last_min_in  = last_min_ff;
      fire_t_in    = fire_t_ff;
      kind_in      = kind_ff;
      today_in     = today_ff;
      hr_in        = hr_ff;
      mn_in        = mn_ff;
      now_in       = now_ff;
      busy_in      = busy_ff;
      old_ref_in   = old_ref_ff;
      off_in       = off_ff;
      limit_in     = limit_ff;
      wd_in        = wd_ff;
      wd_today_in  = wd_today_ff;
      slot_in      = slot_ff;
      nhr_in       = nhr_ff;
      nmn_in       = nmn_ff;
      nday_in      = nday_ff;
      found_in     = found_ff;
      fire_in      = fire_ff;
      dup_in       = dup_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      div_req      = '0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               kind_in    = req_tuser;
               today_in   = req_tdata[15:0];
               hr_in      = req_tdata[20:16];
               mn_in      = req_tdata[26:21];
               now_in     = req_tdata[58:27];
               busy_in    = req_tdata[59];
               old_ref_in = ref_ff;
               fire_in    = 1'b0;
               dup_in     = 1'b0;
               if (req_tuser || ({1'b0, req_tdata[26:21]} != last_min_ff)) begin
                  if (!req_tuser) begin
                     last_min_in = {1'b0, req_tdata[26:21]};
                  end
                  state_in = ST_PREP;
               end
            end
         end
         ST_PREP: begin
            if (n_act == '0) begin
               nhr_in   = '0;
               nmn_in   = '0;
               nday_in  = '0;
               found_in = 1'b0;
               state_in = ST_FIRE_CHK;
            end else begin
               // weekday of today, 0 is sunday
               wd_in       = weekday_of(today_ff);
               wd_today_in = weekday_of(today_ff);
               if (jump && (ref_ff != REF_UNSET)) begin
                  div_req.start    = 1'b1;
                  div_req.dividend = DIV_W'(today_diff);
                  div_req.divisor  = iv_ff;
                  state_in = ST_OFF_WAIT;
               end else begin
                  off_in   = '0;
                  limit_in = jump ? OFF_W'(iv_ff) : OFF_W'(LOOKAHEAD_DAYS);
                  state_in = ST_DAY;
               end
            end
         end
         ST_OFF_WAIT: begin
            if (div_rsp.done) begin
               // align to the first interval day at or after today
               if (today_ff >= ref_ff) begin
                  off_in = (div_rsp.rem != 8'd0) ? OFF_W'(iv_ff - div_rsp.rem) : '0;
                  limit_in = ((div_rsp.rem != 8'd0) ? OFF_W'(iv_ff - div_rsp.rem) : '0)
                             + OFF_W'(iv_ff);
               end else begin
                  off_in   = OFF_W'(div_rsp.rem);
                  limit_in = OFF_W'(div_rsp.rem) + OFF_W'(iv_ff);
               end
               state_in = ST_DAY;
            end
         end
         ST_DAY: begin
            slot_in = '0;
            if (off_ff > limit_ff) begin
               // fallback to slot 0 on the first candidate day past the search window
               nhr_in   = slot_hour(table_ff, SIW'(0));
               nmn_in   = slot_minute(table_ff, SIW'(0));
               nday_in  = day_sat;
               found_in = 1'b0;
               state_in = ST_FIRE_CHK;
            end else begin
               case (pat_ff)
                  PAT_DAILY: state_in = ST_SLOT;
                  PAT_MASK:  state_in = mask_ff[wd_ff] ? ST_SLOT : ST_NEXTDAY;
                  PAT_INTERVAL: begin
                     ref_in = ref_eff;
                     if (iv_ff == 8'd0) begin
                        state_in = ST_SLOT;
                     end else begin
                        div_req.start    = 1'b1;
                        div_req.dividend = day_diff;
                        div_req.divisor  = iv_ff;
                        state_in = ST_DAY_WAIT;
                     end
                  end
                  default: state_in = ST_NEXTDAY;
               endcase
            end
         end
         ST_DAY_WAIT: begin
            if (div_rsp.done) begin
               state_in = (div_rsp.rem == 8'd0) ? ST_SLOT : ST_NEXTDAY;
            end
         end
         ST_SLOT: begin
            if ((off_ff == '0) && ((sh < hr_ff) || ((sh == hr_ff) && (sm <= mn_ff)))) begin
               if (last_slot) begin
                  state_in = ST_NEXTDAY;
               end else begin
                  slot_in = slot_ff + 1'b1;
               end
            end else begin
               nhr_in   = sh;
               nmn_in   = sm;
               nday_in  = day_sat;
               found_in = 1'b1;
               state_in = ST_FIRE_CHK;
            end
         end
         ST_NEXTDAY: begin
            off_in   = off_ff + (jump ? OFF_W'(iv_ff) : OFF_W'(1));
            wd_in    = (wd_ff == 3'd6) ? 3'd0 : wd_ff + 3'd1;
            state_in = ST_DAY;
         end
         ST_FIRE_CHK: begin
            slot_in = '0;
            if (!kind_ff && !busy_ff && (n_act != '0)) begin
               case (pat_ff)
                  PAT_DAILY: state_in = ST_FIRE_SLOT;
                  PAT_MASK:  state_in = mask_ff[wd_today_ff] ? ST_FIRE_SLOT : ST_OUT;
                  PAT_INTERVAL: begin
                     ref_in = tref_eff;
                     if (iv_ff == 8'd0) begin
                        state_in = ST_FIRE_SLOT;
                     end else begin
                        div_req.start    = 1'b1;
                        div_req.dividend = DIV_W'(fire_diff);
                        div_req.divisor  = iv_ff;
                        state_in = ST_FIRE_WAIT;
                     end
                  end
                  default: state_in = ST_OUT;
               endcase
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_FIRE_WAIT: begin
            if (div_rsp.done) begin
               state_in = (div_rsp.rem == 8'd0) ? ST_FIRE_SLOT : ST_OUT;
            end
         end
         ST_FIRE_SLOT: begin
            if ((hr_ff == sh) && (mn_ff == sm)) begin
               // two-hour guard against a repeated start of the same slot
               if ((t_cur != '0) && (now_ff >= t_cur) && ((now_ff - t_cur) < DUP_WINDOW)) begin
                  dup_in = 1'b1;
               end else begin
                  fire_t_in[slot_ff] = now_ff;
                  fire_in = 1'b1;
               end
               state_in = ST_OUT;
            end else if (last_slot) begin
               state_in = ST_OUT;
            end else begin
               slot_in = slot_ff + 1'b1;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, (ref_ff != old_ref_ff), dup_ff, fire_ff, found_ff,
                               nday_ff, nmn_ff, nhr_ff};
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (csr_acc) begin
         unique case (csr_index)
            REG_DAY_PATTERN: pat_in    = csr_wdata[1:0];
            REG_WEEKDAY:     mask_in   = csr_wdata[6:0];
            REG_INTERVAL:    iv_in     = csr_wdata[7:0];
            REG_SLOT_COUNT:  scount_in = csr_wdata[2:0];
            REG_SLOT_TABLE:  table_in  = csr_wdata[TABLE_W-1:0];
            REG_INIT_REF:    ref_in    = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pat_ff       <= PAT_DAILY;
         mask_ff      <= 7'h7F;
         iv_ff        <= 8'd1;
         scount_ff    <= '0;
         table_ff     <= '0;
         ref_ff       <= REF_UNSET;
         last_min_ff  <= 7'd127;
         for (int i = 0; i < SLOTS; i++) begin
            fire_t_ff[i] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pat_ff       <= pat_in;
         mask_ff      <= mask_in;
         iv_ff        <= iv_in;
         scount_ff    <= scount_in;
         table_ff     <= table_in;
         ref_ff       <= ref_in;
         last_min_ff  <= last_min_in;
         fire_t_ff    <= fire_t_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff     <= kind_in;
      today_ff    <= today_in;
      hr_ff       <= hr_in;
      mn_ff       <= mn_in;
      now_ff      <= now_in;
      busy_ff     <= busy_in;
      old_ref_ff  <= old_ref_in;
      off_ff      <= off_in;
      limit_ff    <= limit_in;
      wd_ff       <= wd_in;
      wd_today_ff <= wd_today_in;
      slot_ff     <= slot_in;
      nhr_ff      <= nhr_in;
      nmn_ff      <= nmn_in;
      nday_ff     <= nday_in;
      found_ff    <= found_in;
      fire_ff     <= fire_in;
      dup_ff      <= dup_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_fire_xor_dup: assert property (@(posedge clock) disable iff (reset)
      !(fire_ff && dup_ff) || (state_ff == ST_IDLE))
      else $error("start and duplicate block together");
   a_recompute_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) && kind_ff |-> !fire_ff && !dup_ff)
      else $error("recompute transaction raised a start");
   a_div_done_waiting: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_OFF_WAIT) ||
                       (state_ff == ST_DAY_WAIT) || (state_ff == ST_FIRE_WAIT))
      else $error("remainder finished outside a wait state");
   a_ref_sticky: assert property (@(posedge clock) disable iff (reset)
      (ref_ff != REF_UNSET) && !(csr_acc && (csr_index == REG_INIT_REF))
      |=> ref_ff == $past(ref_ff))
      else $error("reference day changed after being set");

endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// self-checking testbench for the calendar slot alarm scheduler core
// depends on cass_pkg and calendar_slot_alarm_scheduler_core; predicts every response internally
`timescale 1ns / 1ps
module tb_top;
   import cass_pkg::*;

   typedef struct packed {
      logic        latched;
      logic        dup;
      logic        fire;
      logic        found;
      logic [15:0] day;
      logic [5:0]  mn;
      logic [4:0]  hr;
   } sched_result_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        req_tuser = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [31:0] rsp_tdata;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [43:0] csr_wdata = '0;

   calendar_slot_alarm_scheduler_core u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // scheduler shadow state
   logic [1:0]  cfg_pattern;
   logic [6:0]  cfg_mask;
   logic [7:0]  cfg_interval;
   logic [2:0]  cfg_count;
   logic [43:0] cfg_table;
   logic [15:0] cfg_init_ref;
   int unsigned last_min;
   logic [31:0] fire_time [SLOTS];
   int unsigned ref_day;

   sched_result_type pending_results [$];
   int errors = 0;
   int items_sent = 0;
   int results_seen = 0;
   int fires_seen = 0;
   int dups_seen = 0;

   function automatic int unsigned tbl_hour(int i);
      return int'(cfg_table[11*i+6 +: 5]);
   endfunction

   function automatic int unsigned tbl_min(int i);
      return int'(cfg_table[11*i +: 6]);
   endfunction

   function automatic bit day_qualifies(int unsigned day);
      int unsigned diff;
      case (cfg_pattern)
         PAT_DAILY: return 1;
         PAT_MASK: return cfg_mask[(day + 4) % 7];
         PAT_INTERVAL: begin
            if (ref_day == REF_UNSET) ref_day = day & 16'hFFFF;
            diff = (day >= ref_day) ? day - ref_day : ref_day - day;
            if (cfg_interval == 0) return 1;
            return (diff % cfg_interval) == 0;
         end
         default: return 0;
      endcase
   endfunction

   function automatic void predict_item(bit kind, int unsigned today, int unsigned hr,
                                        int unsigned mn, logic [31:0] now, bit busy);
      sched_result_type r;
      int unsigned n, off, lim, day, rem, old_ref;
      bit jump, done;
      r = '0;
      done = 0;
      old_ref = ref_day;
      if (kind == 0) begin
         if (mn == last_min) return;
         last_min = mn;
      end
      n = (cfg_count > SLOTS) ? SLOTS : cfg_count;
      if (n != 0) begin
         off = 0;
         lim = LOOKAHEAD_DAYS;
         jump = (cfg_pattern == PAT_INTERVAL) && (cfg_interval > 0);
         if (jump) begin
            if (ref_day != REF_UNSET) begin
               if (today >= ref_day) begin
                  rem = (today - ref_day) % cfg_interval;
                  off = rem ? cfg_interval - rem : 0;
               end else begin
                  off = (ref_day - today) % cfg_interval;
               end
            end
            lim = off + cfg_interval;
         end
         while (off <= lim && !done) begin
            day = today + off;
            if (day_qualifies(day)) begin
               for (int i = 0; i < n && !done; i++) begin
                  if (off == 0 && (tbl_hour(i) < hr || (tbl_hour(i) == hr && tbl_min(i) <= mn)))
                     continue;
                  r.hr = 5'(tbl_hour(i));
                  r.mn = 6'(tbl_min(i));
                  r.day = (day > 65535) ? 16'hFFFF : day[15:0];
                  r.found = 1;
                  done = 1;
               end
            end
            if (!done) off += jump ? cfg_interval : 1;
         end
         if (!done) begin
            day = today + off;
            r.hr = 5'(tbl_hour(0));
            r.mn = 6'(tbl_min(0));
            r.day = (day > 65535) ? 16'hFFFF : day[15:0];
         end
      end
      if (kind == 0 && busy == 0 && n > 0 && day_qualifies(today)) begin
         done = 0;
         for (int i = 0; i < n && !done; i++) begin
            if (hr == tbl_hour(i) && mn == tbl_min(i)) begin
               if (fire_time[i] > 0 && now >= fire_time[i] && now - fire_time[i] < DUP_WINDOW)
                  r.dup = 1;
               else begin
                  fire_time[i] = now;
                  r.fire = 1;
               end
               done = 1;
            end
         end
      end
      r.latched = (ref_day != old_ref);
      pending_results.push_back(r);
   endfunction

   task automatic send_item(bit kind, logic [15:0] day, logic [4:0] hr, logic [5:0] mn,
                            logic [31:0] now, bit busy, bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17));
      repeat (gap) begin
         req_tvalid = 0;
         @(negedge clock);
      end
      req_tdata = {4'b0, busy, now, mn, hr, day};
      req_tuser = kind;
      req_tvalid = 1;
      do @(posedge clock); while (!req_tready);
      predict_item(kind, {16'd0, day}, {27'd0, hr}, {26'd0, mn}, now, busy);
      items_sent++;
      @(negedge clock);
      req_tvalid = 0;
   endtask

   // drains outstanding responses, then allows for a silently dropped tick
   task automatic wait_idle();
      req_tvalid = 0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (400) @(negedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [43:0] val);
      // registers change only with no transaction in flight
      while (pending_results.size() != 0) @(negedge clock);
      csr_index = idx;
      csr_wdata = val;
      csr_valid = 1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_DAY_PATTERN: cfg_pattern = val[1:0];
         REG_WEEKDAY:     cfg_mask = val[6:0];
         REG_INTERVAL:    cfg_interval = val[7:0];
         REG_SLOT_COUNT:  cfg_count = val[2:0];
         REG_SLOT_TABLE:  cfg_table = val;
         REG_INIT_REF: begin
            cfg_init_ref = val[15:0];
            ref_day = val[15:0];
         end
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 0;
   endtask

   function automatic logic [10:0] slot_code(int h, int m);
      return {h[4:0], m[5:0]};
   endfunction

   // response side: random stalls, with runs of no stall
   initial begin
      int stall;
      @(negedge clock);
      forever begin
         stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
         repeat (stall) begin
            rsp_tready = 0;
            @(negedge clock);
         end
         rsp_tready = 1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      sched_result_type e;
      sched_result_type a;
      if (!reset && rsp_tvalid && rsp_tready) begin
         a = rsp_tdata[30:0];
         if (pending_results.size() == 0) begin
            $error("unexpected response transaction %h", rsp_tdata);
            errors++;
         end else begin
            e = pending_results.pop_front();
            results_seen++;
            fires_seen += a.fire;
            dups_seen += a.dup;
            if (a.hr != e.hr) begin
               $error("upcoming_hour exp %0d got %0d", e.hr, a.hr); errors++;
            end
            if (a.mn != e.mn) begin
               $error("next_minute exp %0d got %0d", e.mn, a.mn); errors++;
            end
            if (a.day != e.day) begin
               $error("next_day exp %0d got %0d", e.day, a.day); errors++;
            end
            if (a.found != e.found) begin
               $error("next_found exp %0d got %0d", e.found, a.found); errors++;
            end
            if (a.fire != e.fire) begin
               $error("start_fire exp %0d got %0d", e.fire, a.fire); errors++;
            end
            if (a.dup != e.dup) begin
               $error("duplicate_blocked exp %0d got %0d", e.dup, a.dup); errors++;
            end
            if (a.latched != e.latched) begin
               $error("reference_latched exp %0d got %0d", e.latched, a.latched); errors++;
            end
         end
      end
   end

   task automatic test_reset_defaults();
      send_item(0, 0, 0, 0, 0, 0);
      send_item(1, 16'd65534, 23, 59, 32'hFFFF_FFFF, 1);
      wait_idle();
   endtask

   task automatic test_daily_slots();
      write_reg(REG_SLOT_TABLE, {slot_code(12, 0), slot_code(23, 59),
                                 slot_code(6, 30), slot_code(0, 0)});
      write_reg(REG_SLOT_COUNT, 4);
      send_item(0, 100, 6, 30, 1000, 0);
      send_item(0, 100, 6, 30, 1010, 0);         // same minute, dropped
      send_item(0, 100, 6, 31, 1060, 0);
      send_item(0, 100, 6, 30, 1000 + 3600, 0);  // inside the guard window
      send_item(0, 100, 6, 31, 1000 + 7200, 0);
      send_item(0, 100, 6, 30, 1000 + 7200, 0);
      send_item(0, 100, 23, 59, 5000, 1);        // busy blocks
      send_item(0, 16'd65534, 23, 58, 32'hFFFF_FFFF, 0);
      send_item(0, 16'd65534, 23, 59, 32'hFFFF_FFFF, 0);
      send_item(1, 16'd65534, 23, 59, 0, 0);
      wait_idle();
   endtask

   task automatic test_weekday_mask();
      write_reg(REG_DAY_PATTERN, PAT_MASK);
      write_reg(REG_WEEKDAY, 7'h41);
      send_item(0, 3, 0, 0, 200000, 0);
      send_item(1, 1, 23, 59, 0, 0);
      write_reg(REG_WEEKDAY, 0);
      send_item(1, 3, 12, 0, 0, 0);
      wait_idle();
   endtask

   task automatic test_interval_mode();
      write_reg(REG_DAY_PATTERN, PAT_INTERVAL);
      write_reg(REG_INTERVAL, 3);
      send_item(0, 500, 6, 29, 300000, 0);       // reference latches here
      send_item(0, 502, 12, 0, 300060, 0);
      write_reg(REG_INIT_REF, 100);
      send_item(1, 90, 0, 0, 0, 0);
      write_reg(REG_INTERVAL, 255);
      send_item(1, 16'd65534, 23, 59, 0, 0);
      write_reg(REG_INTERVAL, 0);
      write_reg(REG_INIT_REF, REF_UNSET);
      send_item(1, 7, 1, 1, 0, 0);
      wait_idle();
   endtask

   task automatic test_odd_settings();
      write_reg(REG_DAY_PATTERN, 3);
      send_item(0, 10, 0, 0, 400000, 0);
      write_reg(REG_DAY_PATTERN, PAT_DAILY);
      write_reg(REG_SLOT_COUNT, 7);
      write_reg(REG_SLOT_TABLE, 44'hFFF_FFFF_FFFF);
      send_item(0, 10, 31, 63, 500000, 0);
      write_reg(REG_SLOT_COUNT, 1);
      send_item(0, 10, 23, 0, 600000, 0);
      wait_idle();
   endtask

   task automatic random_config(int phase);
      logic [43:0] tbl;
      for (int i = 0; i < SLOTS; i++)
         tbl[11*i +: 11] = ($urandom_range(0, 7) == 0) ? 11'($urandom)
                           : slot_code($urandom_range(0, 23), $urandom_range(0, 59));
      write_reg(REG_DAY_PATTERN, 44'((phase < 3) ? phase : $urandom_range(0, 3)));
      write_reg(REG_WEEKDAY, (phase == 1) ? 7'h7F : 7'($urandom));
      write_reg(REG_INTERVAL, (phase == 2) ? 8'd255 : (phase == 4) ? 8'd0
                              : 8'($urandom_range(1, 9)));
      write_reg(REG_SLOT_COUNT, (phase == 5) ? 3'd0 : 3'($urandom_range(1, 7)));
      write_reg(REG_SLOT_TABLE, tbl);
      write_reg(REG_INIT_REF, ($urandom_range(0, 1) == 0) ? REF_UNSET : 16'($urandom));
   endtask

   // mostly a plausible clock marching through slot times, some noise
   task automatic test_random();
      int unsigned day, hr, mn, slot;
      logic [31:0] now;
      for (int phase = 0; phase < 8; phase++) begin
         random_config(phase);
         day = (phase == 6) ? 65520 : $urandom_range(0, 60000);
         hr = $urandom_range(0, 23);
         mn = $urandom_range(0, 59);
         now = $urandom;
         repeat (100) begin
            case ($urandom_range(0, 9))
               0: send_item(1, 16'(day), 5'(hr), 6'(mn), now, 1'($urandom_range(0, 1)));
               1: send_item(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65534)),
                            5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)), $urandom,
                            1'($urandom_range(0, 1)));
               2, 3, 4: begin
                  slot = $urandom_range(0, SLOTS - 1);
                  hr = cfg_table[11*slot+6 +: 5];
                  mn = cfg_table[11*slot +: 6];
                  if ($urandom_range(0, 1)) day = (day + 1) % 65535;
                  now += ($urandom_range(0, 2) == 0) ? $urandom_range(60, 7200) : 86400;
                  send_item(0, 16'(day), 5'(hr), 6'(mn), now, $urandom_range(0, 4) == 0);
               end
               default: begin
                  mn++;
                  if (mn >= 60) begin
                     mn = 0;
                     hr++;
                     if (hr >= 24) begin
                        hr = 0;
                        day = (day + 1) % 65535;
                     end
                  end
                  now += 60;
                  send_item(0, 16'(day), 5'(hr), 6'(mn), now, $urandom_range(0, 4) == 0);
               end
            endcase
         end
         wait_idle();
      end
   endtask

   initial begin
      cfg_pattern = PAT_DAILY;
      cfg_mask = 7'h7F;
      cfg_interval = 1;
      cfg_count = 0;
      cfg_table = '0;
      cfg_init_ref = REF_UNSET;
      last_min = 127;
      ref_day = REF_UNSET;
      for (int i = 0; i < SLOTS; i++) fire_time[i] = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;
      test_reset_defaults();
      test_daily_slots();
      test_weekday_mask();
      test_interval_mode();
      test_odd_settings();
      test_random();
      wait_idle();
      $display("covered %0d input transactions, %0d responses, %0d starts, %0d guarded",
               items_sent, results_seen, fires_seen, dups_seen);
      $display("all day patterns, slot counts 0 to 7 and every register were exercised");
      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/cass_pkg.sv
sv/cass_mod_unit.sv
sv/calendar_slot_alarm_scheduler_core.sv
tb/sv/tb_top.sv
